// ===== design/hstm_pkg.sv =====
// Shared types, constants and helper functions of the hit sequence table match block.
package hstm_pkg;

  // Default table depth; the top level takes its TABLE_DEPTH parameter from here.
  localparam int TABLE_DEPTH_DEF = 256;

  // Number of hit code fields in a request, and how many of them a query may use.
  localparam int HIT_FIELDS = 4;
  localparam int MAX_HITS   = 4;

  // Field widths.
  localparam int CODE_W   = 8;
  localparam int HIT_W    = 9;
  localparam int COUNT_W  = 3;
  localparam int ROW_W    = 8;
  localparam int PROB_W   = 16;
  localparam int MECH_W   = 8;
  localparam int RCOUNT_W = 9;

  // Input request tdata layout, lowest bit first.
  localparam int IN_ROW_LO   = 0;
  localparam int IN_HIT_LO   = 8;
  localparam int IN_CNT_LO   = 44;
  localparam int IN_TAIL_LO  = 47;
  localparam int IN_PROB_LO  = 55;
  localparam int IN_MECH_LO  = 71;
  localparam int IN_ESC_BIT  = 79;
  localparam int IN_DATA_W   = 80;

  // Output request tdata layout.
  localparam int OUT_DATA_W  = 32;

  // Opcodes carried in s_tuser.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_ROW_COUNT   = 1'b0;
  localparam logic CFG_ESCAPE_CODE = 1'b1;
  localparam int   CFG_INDEX_W     = 1;
  localparam int   CFG_DATA_W      = 9;

  // One stored row pattern: tail code, four codes and the hit count (43 bits).
  typedef struct packed {
    logic [CODE_W-1:0]                 tail;
    logic [HIT_FIELDS-1:0][CODE_W-1:0] code;
    logic [COUNT_W-1:0]                count;
  } pattern_t;

  // One stored row payload: mechanism and probability (24 bits).
  typedef struct packed {
    logic [MECH_W-1:0] mech;
    logic [PROB_W-1:0] prob;
  } payload_t;

  // A lookup query as held during a scan.
  typedef struct packed {
    logic [COUNT_W-1:0]                len;
    logic [HIT_FIELDS-1:0][CODE_W-1:0] code;
    logic                              esc_req;
    logic [CODE_W-1:0]                 escape_code;
  } query_t;

  // Query length: leading non-negative codes, at most MAX_HITS of them.
  function automatic logic [COUNT_W-1:0] query_len(
    input logic [HIT_FIELDS-1:0][HIT_W-1:0] hits
  );
    logic [COUNT_W-1:0] len;
    logic               stop;
    len  = '0;
    stop = 1'b0;
    for (int k = 0; k < HIT_FIELDS; k++) begin
      if (!stop && (k < MAX_HITS) && !hits[k][HIT_W-1]) begin
        len = len + COUNT_W'(1);
      end else begin
        stop = 1'b1;
      end
    end
    return len;
  endfunction

endpackage

// ===== design/hstm_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
module hstm_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write when enabled; read data updates only on an enabled access.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

// ===== design/hstm_row_cmp.sv =====
// Compares one stored row pattern against the active lookup query.
module hstm_row_cmp (
  input  hstm_pkg::query_t   query,
  input  hstm_pkg::pattern_t row,
  output logic               hit
);

  logic codes_ok;
  logic esc_ok;

  // Leading codes up to the query length must all agree.
  always_comb begin
    codes_ok = 1'b1;
    for (int j = 0; j < hstm_pkg::HIT_FIELDS; j++) begin
      if ((hstm_pkg::COUNT_W'(j) < query.len) && (row.code[j] != query.code[j])) begin
        codes_ok = 1'b0;
      end
    end
  end

  // The tail check applies only to a nonempty query that asks for it.
  assign esc_ok = !query.esc_req || (query.len == '0) || (row.tail == query.escape_code);

  assign hit = (row.count == query.len) && codes_ok && esc_ok;

endmodule

// ===== design/hit_sequence_table_match_core.sv =====
// Top level of the hit sequence table match block: request decode, scan sequencer, result.
//
// The block keeps a table of TABLE_DEPTH rows in two single-port memories, one for
// the row patterns and one for the probability and mechanism payload. A write request
// (s_tuser = 0) stores one row; row indexes at or above TABLE_DEPTH are dropped. A
// lookup request (s_tuser = 1) starts a scan that reads one row per cycle from the
// pattern memory, compares it in the following cycle, and stops at the first matching
// row or after the last row of min(row_count, TABLE_DEPTH); an empty range ends at once.
// A finished scan holds its result until the output register is free. The next request
// is taken once the result is in the output register. Every lookup gives exactly one
// result; write requests give none. The memories are not cleared: rows below row_count
// must be written before they are looked up. The user must write configuration through
// the cfg port only while no lookup is running; the block itself does not enforce it.
module hit_sequence_table_match_core #(
  parameter int TABLE_DEPTH = hstm_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Request input.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // row_index[7:0], hit0[16:8], hit1[25:17], hit2[34:26], hit3[43:35],
  // row_hit_count[46:44], row_tail_code[54:47], row_probability[70:55],
  // row_mechanism[78:71], escape_required[79]
  input  logic [hstm_pkg::IN_DATA_W-1:0]    s_tdata,
  // opcode[0]
  input  logic                              s_tuser,
  // Result output.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // match_row[7:0], probability[23:8], mechanism[31:24]
  output logic [hstm_pkg::OUT_DATA_W-1:0]   m_tdata,
  // found[0]
  output logic                              m_tuser,
  // Configuration write channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hstm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [hstm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int PAT_W  = $bits(hstm_pkg::pattern_t);
  localparam int PAY_W  = $bits(hstm_pkg::payload_t);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                                   state;
  logic [hstm_pkg::RCOUNT_W-1:0]          row_count;
  logic [hstm_pkg::CODE_W-1:0]            escape_code;
  hstm_pkg::query_t                       query;
  logic [CNT_W-1:0]                       limit;
  logic [CNT_W-1:0]                       iss;
  logic                                   chk_valid;
  logic [ADDR_W-1:0]                      chk_idx;

  logic                                   in_acc;
  logic                                   wr_en;
  logic                                   lookup_start;
  logic [hstm_pkg::ROW_W-1:0]             in_row;
  logic [hstm_pkg::HIT_FIELDS-1:0][hstm_pkg::HIT_W-1:0] in_hits;
  hstm_pkg::pattern_t                     wr_pat;
  hstm_pkg::payload_t                     wr_pay;
  hstm_pkg::pattern_t                     rd_pat;
  hstm_pkg::payload_t                     rd_pay;
  logic [ADDR_W-1:0]                      ram_addr;
  logic                                   ram_en;
  logic                                   row_hit;
  logic                                   finish_hit;
  logic                                   finish_miss;
  logic                                   finish;
  logic                                   out_free;
  logic                                   out_load;
  logic                                   issue;

  // Request decode.
  assign in_acc       = s_tvalid && s_tready;
  assign in_row       = s_tdata[hstm_pkg::IN_ROW_LO +: hstm_pkg::ROW_W];
  assign in_hits      = s_tdata[hstm_pkg::IN_HIT_LO +: hstm_pkg::HIT_FIELDS * hstm_pkg::HIT_W];
  assign wr_en        = in_acc && (s_tuser == hstm_pkg::OP_WRITE) &&
                        (32'(in_row) < TABLE_DEPTH);
  assign lookup_start = in_acc && (s_tuser == hstm_pkg::OP_LOOKUP);

  // Row contents of a write request; codes keep their low byte only.
  always_comb begin
    wr_pat.count = s_tdata[hstm_pkg::IN_CNT_LO +: hstm_pkg::COUNT_W];
    for (int k = 0; k < hstm_pkg::HIT_FIELDS; k++) begin
      wr_pat.code[k] = in_hits[k][hstm_pkg::CODE_W-1:0];
    end
    wr_pat.tail = s_tdata[hstm_pkg::IN_TAIL_LO +: hstm_pkg::CODE_W];
    wr_pay.prob = s_tdata[hstm_pkg::IN_PROB_LO +: hstm_pkg::PROB_W];
    wr_pay.mech = s_tdata[hstm_pkg::IN_MECH_LO +: hstm_pkg::MECH_W];
  end

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count   <= '0;
      escape_code <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hstm_pkg::CFG_ROW_COUNT:   row_count   <= cfg_data;
        hstm_pkg::CFG_ESCAPE_CODE: escape_code <= cfg_data[hstm_pkg::CODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Memory port: the write address while idle, the scan address while scanning.
  assign ram_addr = (state == ST_IDLE) ? ADDR_W'(in_row) : iss[ADDR_W-1:0];
  assign ram_en   = wr_en || issue;

  hstm_ram #(
    .WIDTH (PAT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_pattern_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (wr_en),
    .addr  (ram_addr),
    .wdata (wr_pat),
    .rdata (rd_pat)
  );

  hstm_ram #(
    .WIDTH (PAY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_payload_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (wr_en),
    .addr  (ram_addr),
    .wdata (wr_pay),
    .rdata (rd_pay)
  );

  // Row comparison on the data read in the previous cycle.
  hstm_row_cmp u_row_cmp (
    .query (query),
    .row   (rd_pat),
    .hit   (row_hit)
  );

  // Scan control: stop on the first hit, after the last row, or at once on an empty range.
  assign finish_hit  = (state == ST_SCAN) && chk_valid && row_hit;
  assign finish_miss = (state == ST_SCAN) &&
                       ((chk_valid && !row_hit && (32'(chk_idx) + 1 == 32'(limit))) ||
                        (!chk_valid && (iss >= limit)));
  assign finish      = finish_hit || finish_miss;
  assign out_free    = !m_tvalid || m_tready;
  assign out_load    = finish && out_free;
  assign issue       = (state == ST_SCAN) && !finish && (iss < limit);
  assign s_tready    = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      chk_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          chk_valid <= 1'b0;
          if (lookup_start) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (out_load) begin
            state     <= ST_IDLE;
            chk_valid <= 1'b0;
          end else if (!finish) begin
            chk_valid <= issue;
          end
        end
        default: begin
          state     <= ST_IDLE;
          chk_valid <= 1'b0;
        end
      endcase
    end
  end

  // Query capture and scan counters.
  always_ff @(posedge clk) begin
    if (lookup_start) begin
      query.len         <= hstm_pkg::query_len(in_hits);
      for (int k = 0; k < hstm_pkg::HIT_FIELDS; k++) begin
        query.code[k]   <= in_hits[k][hstm_pkg::CODE_W-1:0];
      end
      query.esc_req     <= s_tdata[hstm_pkg::IN_ESC_BIT];
      query.escape_code <= escape_code;
      limit             <= (32'(row_count) < TABLE_DEPTH) ? CNT_W'(row_count)
                                                          : CNT_W'(TABLE_DEPTH);
      iss               <= '0;
    end else if (issue) begin
      chk_idx           <= iss[ADDR_W-1:0];
      iss               <= iss + CNT_W'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= finish_hit;
      if (finish_hit) begin
        m_tdata <= {rd_pay.mech, rd_pay.prob, hstm_pkg::ROW_W'(chk_idx)};
      end else begin
        m_tdata <= '0;
      end
    end
  end

  // A result appears only at the end of a scan.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_SCAN))
    else $error("result raised outside a scan");

  // A row under comparison always lies inside the scanned range.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) && chk_valid |-> (32'(chk_idx) < 32'(limit)))
    else $error("compared row beyond scan limit");

  // The read pointer never runs past the scan limit.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (iss <= limit))
    else $error("scan pointer beyond limit");

  // A miss carries all-zero data.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (m_tdata == '0))
    else $error("miss result with nonzero data");

endmodule

// ===== tb/sv/tb_hit_sequence_table_match_core.sv =====
// Self-checking testbench for the hit sequence table match core.
`timescale 1ns / 1ps

module tb_hit_sequence_table_match_core;

  localparam int TABLE_DEPTH  = hstm_pkg::TABLE_DEPTH_DEF;
  localparam int DRAIN_CYCLES = 8;
  localparam int SETTLE_CYCLES = 300;
  localparam int STUCK_LIMIT  = 2000;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 90;

  localparam logic PLAN_REQUEST   = 1'b0;
  localparam logic PLAN_REG_WRITE = 1'b1;

  // One request item, split into its fields.
  typedef struct packed {
    logic                                                 op;
    logic [hstm_pkg::ROW_W-1:0]                           row_index;
    logic [hstm_pkg::HIT_FIELDS-1:0][hstm_pkg::HIT_W-1:0] hit;
    logic [hstm_pkg::COUNT_W-1:0]                         cnt;
    logic [hstm_pkg::CODE_W-1:0]                          tail;
    logic [hstm_pkg::PROB_W-1:0]                          prob;
    logic [hstm_pkg::MECH_W-1:0]                          mech;
    logic                                                 esc;
  } request_t;

  // One lookup answer.
  typedef struct packed {
    logic                        found;
    logic [hstm_pkg::ROW_W-1:0]  row;
    logic [hstm_pkg::PROB_W-1:0] prob;
    logic [hstm_pkg::MECH_W-1:0] mech;
  } match_t;

  // One line of the directed stimulus table.
  typedef struct packed {
    logic                            kind;
    request_t                        req;
    logic                            typed;
    match_t                          want;
    logic                            cfg_idx;
    logic [hstm_pkg::CFG_DATA_W-1:0] cfg_val;
  } plan_t;

  logic                              clk = 1'b0;
  logic                              rst;
  logic                              s_tvalid;
  logic                              s_tready;
  logic [hstm_pkg::IN_DATA_W-1:0]    s_tdata;
  logic                              s_tuser;
  logic                              m_tvalid;
  logic                              m_tready;
  logic [hstm_pkg::OUT_DATA_W-1:0]   m_tdata;
  logic                              m_tuser;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [hstm_pkg::CFG_INDEX_W-1:0]  cfg_index;
  logic [hstm_pkg::CFG_DATA_W-1:0]   cfg_data;

  // Mirror of the table and the registers.
  logic [hstm_pkg::COUNT_W-1:0]                          tbl_count [TABLE_DEPTH];
  logic [hstm_pkg::HIT_FIELDS-1:0][hstm_pkg::CODE_W-1:0] tbl_code  [TABLE_DEPTH];
  logic [hstm_pkg::CODE_W-1:0]                           tbl_tail  [TABLE_DEPTH];
  logic [hstm_pkg::PROB_W-1:0]                           tbl_prob  [TABLE_DEPTH];
  logic [hstm_pkg::MECH_W-1:0]                           tbl_mech  [TABLE_DEPTH];
  logic [hstm_pkg::RCOUNT_W-1:0]                         rows_live;
  logic [hstm_pkg::CODE_W-1:0]                           esc_live;

  match_t pending_matches [$];
  plan_t  plan [$];
  match_t got_match;
  int     fails;
  int     stuck_cycles;
  int     send_quiet;
  int     recv_quiet;

  always #5 clk = ~clk;

  hit_sequence_table_match_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Store one written row in the mirror table; codes keep their low byte only.
  function automatic void store_row(input request_t r);
    tbl_count[r.row_index] = r.cnt;
    for (int k = 0; k < hstm_pkg::HIT_FIELDS; k++) begin
      tbl_code[r.row_index][k] = r.hit[k][hstm_pkg::CODE_W-1:0];
    end
    tbl_tail[r.row_index] = r.tail;
    tbl_prob[r.row_index] = r.prob;
    tbl_mech[r.row_index] = r.mech;
  endfunction

  // First-match search over the valid rows.
  function automatic match_t match_lookup(input request_t r);
    match_t res;
    int     len;
    int     lim;
    logic   ended;
    logic   ok;
    res   = '0;
    len   = 0;
    ended = 1'b0;
    for (int k = 0; k < hstm_pkg::HIT_FIELDS; k++) begin
      ended = ended || (k >= hstm_pkg::MAX_HITS) || r.hit[k][hstm_pkg::HIT_W-1];
      if (!ended) len++;
    end
    lim = (rows_live < TABLE_DEPTH) ? rows_live : TABLE_DEPTH;
    for (int i = 0; i < lim; i++) begin
      if (!res.found && tbl_count[i] == len) begin
        ok = 1'b1;
        for (int j = 0; j < len; j++) begin
          if (r.hit[j] != {1'b0, tbl_code[i][j]}) ok = 1'b0;
        end
        // The escape check only counts for a nonempty query.
        if (len > 0 && r.esc && tbl_tail[i] != esc_live) ok = 1'b0;
        if (ok) begin
          res.found = 1'b1;
          res.row   = hstm_pkg::ROW_W'(i);
          res.prob  = tbl_prob[i];
          res.mech  = tbl_mech[i];
        end
      end
    end
    return res;
  endfunction

  // Codes come mostly from a small alphabet so that lookups hit often.
  function automatic logic [hstm_pkg::CODE_W-1:0] pick_code();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 8) return hstm_pkg::CODE_W'($urandom_range(0, 3));
    if (roll == 8) return '1;
    return hstm_pkg::CODE_W'($urandom);
  endfunction

  // A negative hit code: mostly -1, sometimes a random negative value.
  function automatic logic [hstm_pkg::HIT_W-1:0] neg_hit();
    if ($urandom_range(0, 9) < 7) return '1;
    return {1'b1, hstm_pkg::CODE_W'($urandom)};
  endfunction

  function automatic request_t random_request();
    request_t r;
    r.op        = 1'($urandom);
    r.row_index = hstm_pkg::ROW_W'($urandom);
    for (int k = 0; k < hstm_pkg::HIT_FIELDS; k++) r.hit[k] = hstm_pkg::HIT_W'($urandom);
    r.cnt       = hstm_pkg::COUNT_W'($urandom);
    r.tail      = hstm_pkg::CODE_W'($urandom);
    r.prob      = hstm_pkg::PROB_W'($urandom);
    r.mech      = hstm_pkg::MECH_W'($urandom);
    r.esc       = 1'($urandom);
    return r;
  endfunction

  // A write of a well-formed row; a few rows carry counts above four.
  function automatic request_t make_row();
    request_t r;
    r    = random_request();
    r.op = hstm_pkg::OP_WRITE;
    if ($urandom_range(0, 6) == 0) r.cnt = hstm_pkg::COUNT_W'($urandom_range(5, 7));
    else r.cnt = hstm_pkg::COUNT_W'($urandom_range(0, hstm_pkg::MAX_HITS));
    for (int k = 0; k < hstm_pkg::HIT_FIELDS; k++) begin
      if (k < r.cnt) begin
        r.hit[k] = ($urandom_range(0, 9) == 0) ? neg_hit() : {1'b0, pick_code()};
      end
    end
    r.tail = pick_code();
    return r;
  endfunction

  // A lookup, often copied from a live row so that the scan finds something.
  function automatic request_t make_lookup();
    request_t r;
    int       len;
    int       pick;
    int       lim;
    r    = random_request();
    r.op = hstm_pkg::OP_LOOKUP;
    lim  = (rows_live < TABLE_DEPTH) ? rows_live : TABLE_DEPTH;
    if (lim > 0 && $urandom_range(0, 9) < 6) begin
      pick = $urandom_range(0, lim - 1);
      len  = (tbl_count[pick] <= hstm_pkg::MAX_HITS) ? tbl_count[pick]
                                                      : $urandom_range(0, hstm_pkg::MAX_HITS);
      for (int k = 0; k < hstm_pkg::HIT_FIELDS; k++) begin
        if (k < len) r.hit[k] = {1'b0, tbl_code[pick][k]};
      end
      if (tbl_tail[pick] == esc_live) r.esc = 1'($urandom);
      else r.esc = ($urandom_range(0, 3) == 0);
    end else begin
      len = $urandom_range(0, hstm_pkg::MAX_HITS);
      for (int k = 0; k < hstm_pkg::HIT_FIELDS; k++) begin
        if (k < len) r.hit[k] = {1'b0, pick_code()};
      end
    end
    if (len < hstm_pkg::HIT_FIELDS) r.hit[len] = neg_hit();
    return r;
  endfunction

  // Directed table entries.
  task automatic plan_write(input logic [hstm_pkg::ROW_W-1:0] idx,
                            input logic [hstm_pkg::COUNT_W-1:0] cnt,
                            input logic [hstm_pkg::HIT_W-1:0] h0,
                            input logic [hstm_pkg::HIT_W-1:0] h1,
                            input logic [hstm_pkg::HIT_W-1:0] h2,
                            input logic [hstm_pkg::HIT_W-1:0] h3,
                            input logic [hstm_pkg::CODE_W-1:0] tail,
                            input logic [hstm_pkg::PROB_W-1:0] prob,
                            input logic [hstm_pkg::MECH_W-1:0] mech);
    plan_t p;
    p               = '0;
    p.kind          = PLAN_REQUEST;
    p.req.op        = hstm_pkg::OP_WRITE;
    p.req.row_index = idx;
    p.req.hit       = {h3, h2, h1, h0};
    p.req.cnt       = cnt;
    p.req.tail      = tail;
    p.req.prob      = prob;
    p.req.mech      = mech;
    plan.insert(plan.size(), p);
  endtask

  task automatic plan_lookup(input logic [hstm_pkg::HIT_W-1:0] h0,
                             input logic [hstm_pkg::HIT_W-1:0] h1,
                             input logic [hstm_pkg::HIT_W-1:0] h2,
                             input logic [hstm_pkg::HIT_W-1:0] h3,
                             input logic esc, input logic typed, input match_t want);
    plan_t p;
    p         = '0;
    p.kind    = PLAN_REQUEST;
    p.req.op  = hstm_pkg::OP_LOOKUP;
    p.req.hit = {h3, h2, h1, h0};
    p.req.esc = esc;
    p.typed   = typed;
    p.want    = want;
    plan.insert(plan.size(), p);
  endtask

  task automatic plan_reg(input logic idx, input logic [hstm_pkg::CFG_DATA_W-1:0] val);
    plan_t p;
    p         = '0;
    p.kind    = PLAN_REG_WRITE;
    p.cfg_idx = idx;
    p.cfg_val = val;
    plan.insert(plan.size(), p);
  endtask

  // Present one request after a random gap and account for it once it is taken.
  task automatic send_request(input request_t r, input logic typed, input match_t want);
    int gap;
    if (send_quiet > 0) begin
      send_quiet--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 10);
      if ($urandom_range(0, 9) == 0) send_quiet = 20;
    end
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= r.op;
    s_tdata  <= {r.esc, r.mech, r.prob, r.tail, r.cnt, r.hit, r.row_index};
    do @(posedge clk); while (!s_tready);
    if (r.op == hstm_pkg::OP_WRITE) store_row(r);
    else if (typed) pending_matches.insert(pending_matches.size(), want);
    else pending_matches.insert(pending_matches.size(), match_lookup(r));
  endtask

  // Register write once the block has gone idle.
  task automatic write_reg(input logic idx, input logic [hstm_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == hstm_pkg::CFG_ROW_COUNT) rows_live = val;
    else esc_live = val[hstm_pkg::CODE_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [hstm_pkg::PROB_W-1:0] want_v,
                             input logic [hstm_pkg::PROB_W-1:0] got_v);
    if (want_v !== got_v) begin
      fails++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
    end
  endtask

  // Result checking and the stall watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_matches.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, got found=%0d data=%h",
                   $time, m_tuser, m_tdata);
        end else begin
          got_match = pending_matches.pop_front();
          check_field("found", hstm_pkg::PROB_W'(got_match.found),
                      hstm_pkg::PROB_W'(m_tuser));
          check_field("match_row", hstm_pkg::PROB_W'(got_match.row),
                      hstm_pkg::PROB_W'(m_tdata[7:0]));
          check_field("probability", got_match.prob, m_tdata[23:8]);
          check_field("mechanism", hstm_pkg::PROB_W'(got_match.mech),
                      hstm_pkg::PROB_W'(m_tdata[31:24]));
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
          $display("%0t: no request moved for %0d cycles", $time, STUCK_LIMIT);
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  // Result side: random stalls before each result, with quiet stretches.
  initial begin
    int hold;
    m_tready   = 1'b0;
    recv_quiet = 0;
    wait (!rst);
    forever begin
      if (recv_quiet > 0) begin
        recv_quiet--;
        hold = 0;
      end else begin
        hold = $urandom_range(0, 10);
        if ($urandom_range(0, 9) == 0) recv_quiet = 20;
      end
      @(negedge clk);
      if (hold > 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Request side: directed table, table fill, then random phases.
  initial begin
    match_t                        none;
    match_t                        row0;
    request_t                      r;
    logic [hstm_pkg::RCOUNT_W-1:0] rc;
    logic [hstm_pkg::CODE_W-1:0]   ec;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    fails        = 0;
    stuck_cycles = 0;
    send_quiet   = 0;
    rows_live    = '0;
    esc_live     = '1;
    none         = '0;
    row0         = {1'b1, 8'd0, 16'hFFFF, 8'hFF};

    // Empty table after reset, then a small hand-built table.
    plan_lookup(-1, -1, -1, -1, 1'b0, 1'b1, none);
    plan_lookup(255, 255, 255, 255, 1'b1, 1'b1, none);
    plan_write(0, 0, -1, -1, -1, -1, 8'h00, 16'hFFFF, 8'hFF);
    plan_write(1, 4, -1, 0, 255, 128, 8'hFF, 16'h8000, 8'h01);
    plan_write(2, 7, 0, 0, 0, 0, 8'hFF, 16'h1111, 8'h22);
    plan_write(3, 2, 5, 6, -1, -1, 8'h12, 16'h1234, 8'h07);
    plan_write(4, 2, 5, 6, 0, 0, 8'hFF, 16'h4321, 8'h08);
    plan_write(5, 1, 9, 0, 0, 0, 8'h00, 16'h0001, 8'h80);
    plan_reg(hstm_pkg::CFG_ROW_COUNT, 9'd6);
    // An empty query matches the first count-zero row and ignores the escape check.
    plan_lookup(-1, 5, 6, 7, 1'b1, 1'b1, row0);
    // A code written as negative is held as 255.
    plan_lookup(255, 0, 255, 128, 1'b1, 1'b0, none);
    plan_lookup(5, 6, -1, 3, 1'b0, 1'b0, none);
    plan_lookup(5, 6, -1, -1, 1'b1, 1'b0, none);
    // A row with a count above four never matches.
    plan_lookup(0, 0, 0, 0, 1'b0, 1'b0, none);
    plan_lookup(9, -1, 0, 0, 1'b1, 1'b0, none);
    plan_reg(hstm_pkg::CFG_ESCAPE_CODE, 9'd0);
    plan_lookup(9, -1, 0, 0, 1'b1, 1'b0, none);
    plan_lookup(5, 6, -1, -1, 1'b1, 1'b0, none);
    plan_reg(hstm_pkg::CFG_ROW_COUNT, 9'd4);
    plan_lookup(9, -1, -1, -1, 1'b0, 1'b0, none);
    plan_lookup(5, 6, -256, 9, 1'b0, 1'b0, none);
    plan_reg(hstm_pkg::CFG_ESCAPE_CODE, 9'h12);
    plan_lookup(5, 6, -1, -1, 1'b1, 1'b0, none);
    plan_lookup(255, 0, 255, 128, 1'b0, 1'b0, none);
    plan_reg(hstm_pkg::CFG_ROW_COUNT, 9'd0);
    plan_lookup(-1, -1, -1, -1, 1'b0, 1'b1, none);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < plan.size(); i++) begin
      if (plan[i].kind == PLAN_REG_WRITE) write_reg(plan[i].cfg_idx, plan[i].cfg_val);
      else send_request(plan[i].req, plan[i].typed, plan[i].want);
    end

    // Fill every row so that any row count is safe to scan.
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      r           = make_row();
      r.row_index = hstm_pkg::ROW_W'(i);
      send_request(r, 1'b0, none);
    end

    // Random phases, each with its own register setting.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          rc = '1;
          ec = '0;
        end
        1: begin
          rc = hstm_pkg::RCOUNT_W'(TABLE_DEPTH);
          ec = '1;
        end
        2: begin
          rc = 9'd1;
          ec = pick_code();
        end
        3: begin
          rc = hstm_pkg::RCOUNT_W'($urandom_range(2, 40));
          ec = pick_code();
        end
        default: begin
          rc = hstm_pkg::RCOUNT_W'($urandom);
          ec = ($urandom_range(0, 1) == 0) ? pick_code() : hstm_pkg::CODE_W'($urandom);
        end
      endcase
      write_reg(hstm_pkg::CFG_ROW_COUNT, rc);
      write_reg(hstm_pkg::CFG_ESCAPE_CODE, {1'b0, ec});
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 19) == 0) r = random_request();
        else if ($urandom_range(0, 9) < 3) r = make_row();
        else r = make_lookup();
        send_request(r, 1'b0, none);
      end
    end

    // Let the last lookups come out, then allow for a stray result.
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
